>>> sv/ptt_pkg.sv
// Shared types and codes for the periodic task timer table.
// Used by the top level; depends on nothing else.
package ptt_pkg;

	localparam int TICK_W = 32;
	localparam int SLOT_W = 4;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_PAUSE   = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef enum logic {
		KIND_REPLY = 1'b0,
		KIND_FIRED = 1'b1
	} kind_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [TICK_W-1:0] current_tick;
		logic [TICK_W-1:0] interval;
		logic [SLOT_W-1:0] slot;
		logic              pause_flag;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot_id;
		status_t           status;
		logic              last;
	} res_t;

endpackage

>>> sv/ptt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Self-contained; no package dependency.
module ptt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/periodic_task_timer_table.sv
// Periodic task timer table: slot allocation and release, pause control and tick scan.
// Depends on ptt_pkg and ptt_ram (slot periods and last fire ticks).
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | ptt_pkg::cmd_t
//   res     | out       | res_valid, res_stall | ptt_pkg::res_t
//
// Create, destroy and set pause are done without leaving the idle state.
// A tick reads one slot per cycle from the two slot RAMs during the scan,
// then emits a result for each fired slot while res is not stalled.
// Reset clears all live and pause bits at once; no clearing pass is needed.
// A held result in the output register stalls cmd while res_stall is high.
module periodic_task_timer_table #(
	parameter int MAX_TASKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ptt_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output ptt_pkg::res_t res
);

	localparam int TABLE_SIZE = (MAX_TASKS < 16) ? MAX_TASKS : 16;
	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	ptt_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] chk_q, chk_d;
	logic [TABLE_SIZE-1:0] due_q, due_d;
	logic [TABLE_SIZE-1:0] valid_q, paused_q;
	logic [ptt_pkg::TICK_W-1:0] now_q;
	ptt_pkg::res_t res_q, load_res;
	logic res_valid_q;
	logic load;

	logic cmd_acc, out_free, cmd_in_range, table_full, scan_due;
	logic [IDX_W-1:0] cmd_idx, free_idx, fire_idx;
	logic [TABLE_SIZE-1:0] fire_rest;

	logic per_we, last_we, rd_en;
	logic [IDX_W-1:0] wr_idx, rd_idx;
	logic [ptt_pkg::TICK_W-1:0] last_wdata, period_rd, last_rd;

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign out_free = !res_valid_q || !res_stall;
	assign cmd_in_range = 32'(cmd.slot) < TABLE_SIZE;
	assign cmd_idx = cmd.slot[IDX_W-1:0];

	always_comb begin
		free_idx = '0;
		table_full = 1'b1;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				table_full = 1'b0;
			end
		end
	end

	always_comb begin
		fire_idx = '0;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if (due_q[i]) begin
				fire_idx = IDX_W'(i);
			end
		end
		fire_rest = due_q;
		fire_rest[fire_idx] = 1'b0;
	end

	assign scan_due = valid_q[chk_q] && !paused_q[chk_q] && ((now_q - last_rd) >= period_rd);

	ptt_ram #(
		.WIDTH(ptt_pkg::TICK_W),
		.DEPTH(TABLE_SIZE)
	) u_period_ram (
		.clk  (clk),
		.we   (per_we),
		.waddr(wr_idx),
		.wdata(cmd.interval),
		.re   (rd_en),
		.raddr(rd_idx),
		.rdata(period_rd)
	);

	ptt_ram #(
		.WIDTH(ptt_pkg::TICK_W),
		.DEPTH(TABLE_SIZE)
	) u_last_ram (
		.clk  (clk),
		.we   (last_we),
		.waddr(wr_idx),
		.wdata(last_wdata),
		.re   (rd_en),
		.raddr(rd_idx),
		.rdata(last_rd)
	);

	always_comb begin
		state_d = state_q;
		chk_d = chk_q;
		due_d = due_q;
		per_we = 1'b0;
		last_we = 1'b0;
		wr_idx = free_idx;
		last_wdata = cmd.current_tick;
		rd_en = 1'b0;
		rd_idx = chk_q + IDX_W'(1);
		load = 1'b0;
		load_res = '0;
		cmd_stall = (state_q != ptt_pkg::ST_IDLE) || (res_valid_q && res_stall);
		unique case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					unique case (cmd.operation)
						ptt_pkg::OP_CREATE: begin
							per_we = !table_full;
							last_we = !table_full;
							load = 1'b1;
							load_res.kind = ptt_pkg::KIND_REPLY;
							load_res.slot_id = table_full ? '0 : ptt_pkg::SLOT_W'(free_idx);
							load_res.status = table_full ? ptt_pkg::STATUS_FULL
								: ptt_pkg::STATUS_OK;
							load_res.last = 1'b1;
						end
						ptt_pkg::OP_TICK: begin
							rd_en = 1'b1;
							rd_idx = '0;
							chk_d = '0;
							due_d = '0;
							state_d = ptt_pkg::ST_SCAN;
						end
						ptt_pkg::OP_DESTROY, ptt_pkg::OP_PAUSE: begin
						end
						default: begin
						end
					endcase
				end
			end
			ptt_pkg::ST_SCAN: begin
				last_we = scan_due;
				wr_idx = chk_q;
				last_wdata = now_q;
				due_d[chk_q] = scan_due;
				if (chk_q == LAST_IDX) begin
					state_d = (due_d != '0) ? ptt_pkg::ST_EMIT : ptt_pkg::ST_IDLE;
				end else begin
					rd_en = 1'b1;
					chk_d = chk_q + IDX_W'(1);
				end
			end
			ptt_pkg::ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					load_res.kind = ptt_pkg::KIND_FIRED;
					load_res.slot_id = ptt_pkg::SLOT_W'(fire_idx);
					load_res.status = ptt_pkg::STATUS_OK;
					load_res.last = (fire_rest == '0);
					due_d = fire_rest;
					if (fire_rest == '0) begin
						state_d = ptt_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ptt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
			chk_q <= '0;
			due_q <= '0;
			valid_q <= '0;
			paused_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q <= chk_d;
			due_q <= due_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cmd_acc) begin
				case (cmd.operation)
					ptt_pkg::OP_CREATE: begin
						if (!table_full) begin
							valid_q[free_idx] <= 1'b1;
							paused_q[free_idx] <= 1'b0;
						end
					end
					ptt_pkg::OP_DESTROY: begin
						if (cmd_in_range) begin
							valid_q[cmd_idx] <= 1'b0;
							paused_q[cmd_idx] <= 1'b0;
						end
					end
					ptt_pkg::OP_PAUSE: begin
						if (cmd_in_range && valid_q[cmd_idx]) begin
							paused_q[cmd_idx] <= cmd.pause_flag;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
		if (cmd_acc && cmd.operation == ptt_pkg::OP_TICK) begin
			now_q <= cmd.current_tick;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_create_goes_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.operation == ptt_pkg::OP_CREATE && !table_full
		|=> valid_q[$past(free_idx)])
		else $error("Created slot did not become live.");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptt_pkg::ST_SCAN && chk_q == LAST_IDX |=> state_q != ptt_pkg::ST_SCAN)
		else $error("Tick scan ran past the last slot.");

	a_fired_is_live: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ptt_pkg::KIND_FIRED |-> valid_q[res.slot_id[IDX_W-1:0]])
		else $error("Fired request names a slot that is not live.");

	a_more_to_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ptt_pkg::KIND_FIRED && !res.last
		|-> state_q == ptt_pkg::ST_EMIT)
		else $error("Non-final fired request without further slots pending.");

endmodule

>>> dv/tb_periodic_task_timer_table.sv
// Testbench for periodic_task_timer_table: a directed table, then random requests,
// checked against a cycle-free slot table model here or a directed row's own reply.
// Depends on ptt_pkg and the periodic_task_timer_table RTL.
module tb_periodic_task_timer_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = 16;
	localparam int RANDOM_REQUESTS = 405;
	localparam int PRESSURE_HOLD = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		ptt_pkg::cmd_t c;
		bit            typed;
		ptt_pkg::res_t r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	ptt_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ptt_pkg::res_t res;

	logic        live [TABLE_SLOTS];
	logic        paused [TABLE_SLOTS];
	logic [31:0] period [TABLE_SLOTS];
	logic [31:0] last_fire [TABLE_SLOTS];

	ptt_pkg::res_t owed_events[$];
	dir_row_t      directed_rows[$];

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int n_checked = 0;
	int n_fired = 0;
	int n_full = 0;
	int n_ops [4];

	periodic_task_timer_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic void timer_table_step(input ptt_pkg::cmd_t c,
			output ptt_pkg::res_t evs[$]);
		ptt_pkg::res_t e;
		logic [31:0]   elapsed;
		int            i;
		evs = {};
		case (c.operation)
			ptt_pkg::OP_CREATE: begin
				e.kind = ptt_pkg::KIND_REPLY;
				e.slot_id = '0;
				e.status = ptt_pkg::STATUS_FULL;
				e.last = 1'b1;
				for (i = 0; i < TABLE_SLOTS; i++) begin
					if (!live[i]) begin
						live[i] = 1'b1;
						paused[i] = 1'b0;
						period[i] = c.interval;
						last_fire[i] = c.current_tick;
						e.slot_id = 4'(i);
						e.status = ptt_pkg::STATUS_OK;
						break;
					end
				end
				evs.push_back(e);
			end
			ptt_pkg::OP_DESTROY: begin
				live[c.slot] = 1'b0;
				paused[c.slot] = 1'b0;
			end
			ptt_pkg::OP_PAUSE: begin
				if (live[c.slot])
					paused[c.slot] = c.pause_flag;
			end
			default: begin
				for (i = 0; i < TABLE_SLOTS; i++) begin
					elapsed = c.current_tick - last_fire[i];
					if (live[i] && !paused[i] && elapsed >= period[i]) begin
						last_fire[i] = c.current_tick;
						e.kind = ptt_pkg::KIND_FIRED;
						e.slot_id = 4'(i);
						e.status = ptt_pkg::STATUS_OK;
						e.last = 1'b0;
						evs.push_back(e);
					end
				end
				if (evs.size() > 0) begin
					e = evs[evs.size()-1];
					e.last = 1'b1;
					evs[evs.size()-1] = e;
				end
			end
		endcase
	endfunction

	function automatic ptt_pkg::res_t reply(input int slot, input ptt_pkg::status_t st);
		ptt_pkg::res_t r;
		r.kind = ptt_pkg::KIND_REPLY;
		r.slot_id = 4'(slot);
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void add_row(input ptt_pkg::op_t op, input logic [31:0] tick,
			input logic [31:0] ivl, input int slot, input bit pf,
			input bit typed, input ptt_pkg::res_t r);
		dir_row_t row;
		row.c.operation = op;
		row.c.current_tick = tick;
		row.c.interval = ivl;
		row.c.slot = 4'(slot);
		row.c.pause_flag = pf;
		row.typed = typed;
		row.r = r;
		directed_rows.push_back(row);
	endfunction

	// Offer one request and wait for it to be taken; the model is updated on acceptance.
	task automatic send(input ptt_pkg::cmd_t c, input bit typed, input ptt_pkg::res_t r);
		ptt_pkg::res_t evs[$];
		@(negedge clk);
		while (!calm && $urandom_range(99) < 13) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		timer_table_step(c, evs);
		n_ops[c.operation]++;
		if (typed)
			owed_events.push_back(r);
		else
			foreach (evs[k]) owed_events.push_back(evs[k]);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = PRESSURE_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !calm && $urandom_range(99) < 13;
		end
	end

	always @(posedge clk) begin
		ptt_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_checked++;
			if (res.kind == ptt_pkg::KIND_FIRED)
				n_fired++;
			if (res.status == ptt_pkg::STATUS_FULL)
				n_full++;
			if (owed_events.size() == 0) begin
				report_mismatch($sformatf("unexpected result slot %0d", res.slot_id));
			end else begin
				want = owed_events.pop_front();
				if (res.kind != want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", res.kind, want.kind));
				if (res.slot_id != want.slot_id)
					report_mismatch($sformatf("slot_id %0d, want %0d", res.slot_id,
						want.slot_id));
				if (res.status != want.status)
					report_mismatch($sformatf("status %0d, want %0d", res.status,
						want.status));
				if (res.last != want.last)
					report_mismatch($sformatf("last %0d, want %0d", res.last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
				$display("tb_periodic_task_timer_table: FAIL");
				$finish;
			end
		end
	end

	initial begin
		ptt_pkg::cmd_t c;
		logic [31:0]   clock_now;
		int            pick;
		int            tries;
		int            n;
		foreach (live[i]) begin
			live[i] = 1'b0;
			paused[i] = 1'b0;
			period[i] = '0;
			last_fire[i] = '0;
		end
		foreach (n_ops[i]) n_ops[i] = 0;

		add_row(ptt_pkg::OP_TICK, 32'd0, 32'd0, 0, 1'b0, 1'b0, '0);
		add_row(ptt_pkg::OP_CREATE, 32'd0, 32'd0, 0, 1'b0, 1'b1,
			reply(0, ptt_pkg::STATUS_OK));
		add_row(ptt_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15, 1'b1, 1'b1,
			reply(1, ptt_pkg::STATUS_OK));
		for (int s = 2; s < TABLE_SLOTS; s++)
			add_row(ptt_pkg::OP_CREATE, 32'd100, 32'(s), 0, 1'b0, 1'b1,
				reply(s, ptt_pkg::STATUS_OK));
		add_row(ptt_pkg::OP_CREATE, 32'd100, 32'd7, 0, 1'b0, 1'b1,
			reply(0, ptt_pkg::STATUS_FULL));
		add_row(ptt_pkg::OP_TICK, 32'd110, 32'hAAAA_5555, 0, 1'b0, 1'b0, '0);
		add_row(ptt_pkg::OP_PAUSE, 32'h5555_AAAA, 32'd0, 0, 1'b1, 1'b0, '0);
		add_row(ptt_pkg::OP_DESTROY, 32'd0, 32'hFFFF_FFFF, 3, 1'b1, 1'b0, '0);
		add_row(ptt_pkg::OP_PAUSE, 32'd0, 32'd0, 3, 1'b1, 1'b0, '0);
		add_row(ptt_pkg::OP_CREATE, 32'd200, 32'd5, 0, 1'b0, 1'b1,
			reply(3, ptt_pkg::STATUS_OK));
		add_row(ptt_pkg::OP_TICK, 32'hFFFF_FFFE, 32'd0, 0, 1'b0, 1'b0, '0);
		add_row(ptt_pkg::OP_PAUSE, 32'd0, 32'd0, 0, 1'b0, 1'b0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);

		clock_now = 32'hFFFF_FFFE;
		n = 0;
		while (n < RANDOM_REQUESTS) begin
			if (n == 60)
				hold_req = 1'b1;
			calm = (n >= 200 && n < 280);
			c.current_tick = $urandom;
			c.interval = $urandom;
			c.slot = 4'($urandom_range(15));
			c.pause_flag = 1'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 22)
				c.operation = ptt_pkg::OP_CREATE;
			else if (pick < 36)
				c.operation = ptt_pkg::OP_DESTROY;
			else if (pick < 50)
				c.operation = ptt_pkg::OP_PAUSE;
			else
				c.operation = ptt_pkg::OP_TICK;
			if (c.operation == ptt_pkg::OP_CREATE || c.operation == ptt_pkg::OP_TICK) begin
				if ($urandom_range(99) < 6)
					clock_now = $urandom;
				else
					clock_now = clock_now + $urandom_range(40);
				c.current_tick = clock_now;
				pick = $urandom_range(9);
				if (pick <= 5)
					c.interval = $urandom_range(50);
				else if (pick == 6)
					c.interval = '0;
				else if (pick == 7)
					c.interval = 32'hFFFF_FFFF;
			end else if ($urandom_range(99) < 70) begin
				for (tries = 0; tries < 32 && !live[c.slot]; tries++)
					c.slot = 4'($urandom_range(15));
			end
			send(c, 1'b0, '0);
			n++;
		end
		calm = 1'b0;
		@(negedge clk);
		cmd_valid <= 1'b0;

		while (owed_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (owed_events.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", owed_events.size()));

		$display("requests: %0d create, %0d destroy, %0d set pause, %0d tick",
			n_ops[ptt_pkg::OP_CREATE], n_ops[ptt_pkg::OP_DESTROY],
			n_ops[ptt_pkg::OP_PAUSE], n_ops[ptt_pkg::OP_TICK]);
		$display("results checked: %0d, of which %0d fired and %0d table full, %0d errors",
			n_checked, n_fired, n_full, errors);
		if (errors == 0) begin
			$display("tb_periodic_task_timer_table: PASS");
		end else begin
			$display("tb_periodic_task_timer_table: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/ptt_pkg.sv
sv/ptt_ram.sv
sv/periodic_task_timer_table.sv
dv/tb_periodic_task_timer_table.sv
